>>> rtl/mvna_pkg.sv
// Package for the mesh vertex normal accumulator.
// Holds field widths, request codes, state types and the normalizer status struct.
// No dependencies.
package mvna_pkg;

    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int NORM_W  = 16;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    // wide enough for a cross product component and for an accumulator of up to 36 bits
    localparam int VEC_W   = 36;
    localparam int ROOT_W  = 32;
    localparam int SUM_W   = 64;
    localparam int QUOT_W  = 15;
    localparam int FRAC_W  = 14;

    localparam logic [NORM_W-1:0] Q_ONE     = 16'd16384;
    localparam logic [VEC_W-1:0]  MAG_LIMIT = 36'h0_8000_0000;

    localparam logic [1:0] FUNC_STORE = 2'd0;
    localparam logic [1:0] FUNC_TRI   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_VRD1,
        ST_VRD2,
        ST_VRD3,
        ST_CROSS,
        ST_NSTART,
        ST_NWAIT,
        ST_RDDATA,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SHIFT,
        NS_SQUARE,
        NS_ROOT,
        NS_DIVLOAD,
        NS_DIV,
        NS_DONE
    } norm_state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_res_t;

endpackage

>>> rtl/mvna_norm.sv
// Iterative normalizer: scales a signed integer vector to a Q1.14 unit vector.
// Uses a shared squarer, a bit-serial square root and a restoring divider.
// Depends on mvna_pkg.
module mvna_norm
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mvna_pkg::VEC_W-1:0]   vec_x,
    input  logic signed [mvna_pkg::VEC_W-1:0]   vec_y,
    input  logic signed [mvna_pkg::VEC_W-1:0]   vec_z,
    output mvna_pkg::norm_res_t                 status,
    output logic signed [mvna_pkg::NORM_W-1:0]  n_x,
    output logic signed [mvna_pkg::NORM_W-1:0]  n_y,
    output logic signed [mvna_pkg::NORM_W-1:0]  n_z
);

    localparam int VW = mvna_pkg::VEC_W;
    localparam int RW = mvna_pkg::ROOT_W;
    localparam int SW = mvna_pkg::SUM_W;
    localparam int QW = mvna_pkg::QUOT_W;
    localparam int FW = mvna_pkg::FRAC_W;
    localparam int NW = mvna_pkg::NORM_W;
    localparam int NUM_W = RW + FW;

    mvna_pkg::norm_state_t state_reg, state_next;

    logic [4:0]    cnt_reg;
    logic [1:0]    k_reg;
    logic [VW-1:0] m_reg [3];
    logic          neg_reg [3];
    logic [SW-1:0] prod_reg;
    logic [SW-1:0] s_reg;
    logic [SW-1:0] res_reg;
    logic [SW-1:0] bit_reg;
    logic [RW:0]   rem_reg;
    logic [QW-1:0] nlow_reg;
    logic [QW-1:0] q_reg;
    logic signed [NW-1:0] n_reg [3];
    logic          zero_reg;

    logic [VW-1:0]  mx;
    logic [SW-1:0]  trial;
    logic [RW-1:0]  r;
    logic [NUM_W-1:0] num;
    logic [RW+1:0]  t;
    logic           t_ge;
    logic [QW-1:0]  q_next;
    logic [NW-1:0]  q_clamp;

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
        trial   = res_reg + bit_reg;
        r       = res_reg[RW-1:0];
        num     = {m_reg[k_reg][RW-1:0], {FW{1'b0}}} + NUM_W'(r >> 1);
        t       = {rem_reg, nlow_reg[QW-1]};
        t_ge    = (t >= {2'b00, r});
        q_next  = {q_reg[QW-2:0], t_ge};
        q_clamp = ({1'b0, q_next} > mvna_pkg::Q_ONE) ? mvna_pkg::Q_ONE : {1'b0, q_next};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvna_pkg::NS_IDLE:
            begin
                if (start)
                begin
                    state_next = mvna_pkg::NS_SHIFT;
                end
            end
            mvna_pkg::NS_SHIFT:
            begin
                if (mx <= mvna_pkg::MAG_LIMIT)
                begin
                    state_next = mvna_pkg::NS_SQUARE;
                end
            end
            mvna_pkg::NS_SQUARE:
            begin
                if (cnt_reg == 5'd3)
                begin
                    state_next = mvna_pkg::NS_ROOT;
                end
            end
            mvna_pkg::NS_ROOT:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = mvna_pkg::NS_DIVLOAD;
                end
            end
            mvna_pkg::NS_DIVLOAD:
            begin
                state_next = (res_reg == '0) ? mvna_pkg::NS_DONE : mvna_pkg::NS_DIV;
            end
            mvna_pkg::NS_DIV:
            begin
                if (cnt_reg == 5'(QW - 1))
                begin
                    state_next = (k_reg == 2'd2) ? mvna_pkg::NS_DONE : mvna_pkg::NS_DIVLOAD;
                end
            end
            mvna_pkg::NS_DONE:
            begin
                state_next = mvna_pkg::NS_IDLE;
            end
            default:
            begin
                state_next = mvna_pkg::NS_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        status.done = (state_reg == mvna_pkg::NS_DONE);
        status.zero = zero_reg;
        n_x = n_reg[0];
        n_y = n_reg[1];
        n_z = n_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvna_pkg::NS_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mvna_pkg::NS_SHIFT:
                begin
                    cnt_reg <= '0;
                end
                mvna_pkg::NS_SQUARE:
                begin
                    cnt_reg <= (cnt_reg == 5'd3) ? 5'd0 : cnt_reg + 5'd1;
                end
                mvna_pkg::NS_ROOT:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    k_reg   <= '0;
                end
                mvna_pkg::NS_DIVLOAD:
                begin
                    cnt_reg <= '0;
                end
                mvna_pkg::NS_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(QW - 1))
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mvna_pkg::NS_IDLE:
            begin
                if (start)
                begin
                    m_reg[0]   <= vec_x[VW-1] ? VW'(-vec_x) : VW'(vec_x);
                    m_reg[1]   <= vec_y[VW-1] ? VW'(-vec_y) : VW'(vec_y);
                    m_reg[2]   <= vec_z[VW-1] ? VW'(-vec_z) : VW'(vec_z);
                    neg_reg[0] <= vec_x[VW-1];
                    neg_reg[1] <= vec_y[VW-1];
                    neg_reg[2] <= vec_z[VW-1];
                    zero_reg   <= 1'b0;
                    s_reg      <= '0;
                end
            end
            mvna_pkg::NS_SHIFT:
            begin
                // drop one bit at a time until every magnitude fits 2^31
                if (mx > mvna_pkg::MAG_LIMIT)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
            end
            mvna_pkg::NS_SQUARE:
            begin
                if (cnt_reg != 5'd3)
                begin
                    prod_reg <= SW'(m_reg[cnt_reg[1:0]][RW-1:0])
                              * SW'(m_reg[cnt_reg[1:0]][RW-1:0]);
                end
                if (cnt_reg != 5'd0)
                begin
                    s_reg <= s_reg + prod_reg;
                end
                res_reg <= '0;
                bit_reg <= SW'(1) << (SW - 2);
            end
            mvna_pkg::NS_ROOT:
            begin
                if (s_reg >= trial)
                begin
                    s_reg   <= s_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            mvna_pkg::NS_DIVLOAD:
            begin
                if (res_reg == '0)
                begin
                    zero_reg <= 1'b1;
                    n_reg[0] <= '0;
                    n_reg[1] <= '0;
                    n_reg[2] <= '0;
                end
                rem_reg  <= (RW + 1)'(num[NUM_W-1:QW]);
                nlow_reg <= num[QW-1:0];
                q_reg    <= '0;
            end
            mvna_pkg::NS_DIV:
            begin
                rem_reg  <= t_ge ? (RW + 1)'(t - {2'b00, r}) : (RW + 1)'(t);
                nlow_reg <= nlow_reg << 1;
                q_reg    <= q_next;
                if (cnt_reg == 5'(QW - 1))
                begin
                    n_reg[k_reg] <= neg_reg[k_reg] ? -$signed(q_clamp) : $signed(q_clamp);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/mesh_vertex_normal_accumulator.sv
// Mesh vertex normal accumulator: vertex store, per-vertex normal sums, readout.
// Depends on mvna_pkg and mvna_norm.
//
// Store and clear write their memory in the decode state; a triangle takes
// 3 vertex reads, 6 shared multiplies, the normalizer and 3 accumulator RMWs;
// a read takes an accumulator read and the bit-serial root and divider.
// Throughput: one request at a time; the next is taken once the last is done.
// Reset: state clears at once, then a sweep zeroes every accumulator with req_stall high.
module mesh_vertex_normal_accumulator
#(
    parameter int VERTEX_COUNT = 1024,
    parameter int ACC_BITS     = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          func,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_c,
    input  logic signed [mvna_pkg::COORD_W-1:0] pos_x,
    input  logic signed [mvna_pkg::COORD_W-1:0] pos_y,
    input  logic signed [mvna_pkg::COORD_W-1:0] pos_z,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [mvna_pkg::NORM_W-1:0]  norm_x,
    output logic signed [mvna_pkg::NORM_W-1:0]  norm_y,
    output logic signed [mvna_pkg::NORM_W-1:0]  norm_z,
    output logic                                zero_length
);

    localparam int AW  = $clog2(VERTEX_COUNT);
    localparam int CW  = mvna_pkg::COORD_W;
    localparam int IW  = mvna_pkg::IDX_W;
    localparam int EW  = mvna_pkg::EDGE_W;
    localparam int PW  = mvna_pkg::PROD_W;
    localparam int VW  = mvna_pkg::VEC_W;
    localparam int NW  = mvna_pkg::NORM_W;
    localparam int AB1 = ACC_BITS + 1;
    localparam int DW  = 3 * ACC_BITS;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

    mvna_pkg::top_state_t state_reg, state_next;

    // request hold
    logic [1:0]    func_reg;
    logic [IW-1:0] ca_reg, cb_reg, cc_reg;
    logic [3*CW-1:0] pos_reg;

    logic [AW-1:0] clr_addr_reg;
    logic [2:0]    cnt_reg;
    logic [1:0]    k_reg;
    logic          bad_reg;

    logic signed [CW-1:0] p0_reg [3];
    logic signed [CW-1:0] p1_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [VW-1:0] nv_reg [3];

    // memories
    logic [3*CW-1:0] vmem [VERTEX_COUNT];
    logic [3*CW-1:0] vq_reg;
    logic [DW-1:0]   amem [VERTEX_COUNT];
    logic [DW-1:0]   aq_reg;

    logic            v_we;
    logic [AW-1:0]   v_addr;
    logic            a_we;
    logic [AW-1:0]   a_addr;
    logic [DW-1:0]   a_wd;
    logic            norm_start;

    // response register
    logic            rsp_valid_reg;
    logic signed [NW-1:0] rx_reg, ry_reg, rz_reg;
    logic            rzero_reg;

    mvna_pkg::norm_res_t norm_st;
    logic signed [NW-1:0] n_x, n_y, n_z;

    logic a_ok, b_ok, c_ok;
    logic [IW-1:0] corner_k;
    logic signed [EW-1:0] mul_a, mul_b;
    logic [2:0] j;
    logic [1:0] comp;
    logic signed [ACC_BITS-1:0] acc_old [3];
    logic signed [ACC_BITS-1:0] acc_new [3];
    logic signed [NW-1:0] addend [3];
    logic signed [AB1-1:0] sum [3];
    logic out_free;

    mvna_norm u_norm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .vec_x  (nv_reg[0]),
        .vec_y  (nv_reg[1]),
        .vec_z  (nv_reg[2]),
        .status (norm_st),
        .n_x    (n_x),
        .n_y    (n_y),
        .n_z    (n_z)
    );

    // index range checks and shared datapath pieces
    always_comb
    begin
        a_ok = ({22'd0, ca_reg} < 32'(VERTEX_COUNT));
        b_ok = ({22'd0, cb_reg} < 32'(VERTEX_COUNT));
        c_ok = ({22'd0, cc_reg} < 32'(VERTEX_COUNT));

        case (k_reg)
            2'd0:    corner_k = ca_reg;
            2'd1:    corner_k = cb_reg;
            default: corner_k = cc_reg;
        endcase

        // cross product term order: yz, zy, zx, xz, xy, yx
        case (cnt_reg)
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
        j    = cnt_reg - 3'd1;
        comp = j[2:1];

        addend[0] = n_x;
        addend[1] = n_y;
        addend[2] = n_z;
        for (int i = 0; i < 3; i++)
        begin
            acc_old[i] = aq_reg[i*ACC_BITS +: ACC_BITS];
            sum[i]     = AB1'(acc_old[i]) + AB1'(addend[i]);
            // saturate when the carry and sign bits disagree
            if (sum[i][AB1-1] != sum[i][AB1-2])
            begin
                acc_new[i] = sum[i][AB1-1] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                acc_new[i] = sum[i][ACC_BITS-1:0];
            end
        end

        out_free = !rsp_valid_reg || !rsp_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvna_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(VERTEX_COUNT - 1))
                begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            mvna_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = mvna_pkg::ST_DECODE;
                end
            end
            mvna_pkg::ST_DECODE:
            begin
                case (func_reg)
                    mvna_pkg::FUNC_TRI:
                    begin
                        state_next = (a_ok && b_ok && c_ok) ? mvna_pkg::ST_VRD1
                                                            : mvna_pkg::ST_IDLE;
                    end
                    mvna_pkg::FUNC_READ:
                    begin
                        state_next = a_ok ? mvna_pkg::ST_RDDATA : mvna_pkg::ST_OUT;
                    end
                    default:
                    begin
                        state_next = mvna_pkg::ST_IDLE;
                    end
                endcase
            end
            mvna_pkg::ST_VRD1:   state_next = mvna_pkg::ST_VRD2;
            mvna_pkg::ST_VRD2:   state_next = mvna_pkg::ST_VRD3;
            mvna_pkg::ST_VRD3:   state_next = mvna_pkg::ST_CROSS;
            mvna_pkg::ST_CROSS:
            begin
                if (cnt_reg == 3'd6)
                begin
                    state_next = mvna_pkg::ST_NSTART;
                end
            end
            mvna_pkg::ST_RDDATA: state_next = mvna_pkg::ST_NSTART;
            mvna_pkg::ST_NSTART: state_next = mvna_pkg::ST_NWAIT;
            mvna_pkg::ST_NWAIT:
            begin
                if (norm_st.done)
                begin
                    if (func_reg == mvna_pkg::FUNC_READ)
                    begin
                        state_next = mvna_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = norm_st.zero ? mvna_pkg::ST_IDLE : mvna_pkg::ST_ACC_RD;
                    end
                end
            end
            mvna_pkg::ST_ACC_RD: state_next = mvna_pkg::ST_ACC_WR;
            mvna_pkg::ST_ACC_WR:
            begin
                state_next = (k_reg == 2'd2) ? mvna_pkg::ST_IDLE : mvna_pkg::ST_ACC_RD;
            end
            mvna_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvna_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        req_stall  = (state_reg != mvna_pkg::ST_IDLE);
        norm_start = (state_reg == mvna_pkg::ST_NSTART);
        v_we       = 1'b0;
        v_addr     = AW'(ca_reg);
        a_we       = 1'b0;
        a_addr     = AW'(ca_reg);
        a_wd       = '0;
        case (state_reg)
            mvna_pkg::ST_CLEAR:
            begin
                a_we   = 1'b1;
                a_addr = clr_addr_reg;
            end
            mvna_pkg::ST_DECODE:
            begin
                v_we = (func_reg == mvna_pkg::FUNC_STORE) && a_ok;
                a_we = (func_reg == mvna_pkg::FUNC_CLEAR) && a_ok;
            end
            mvna_pkg::ST_VRD1:
            begin
                v_addr = AW'(cb_reg);
            end
            mvna_pkg::ST_VRD2:
            begin
                v_addr = AW'(cc_reg);
            end
            mvna_pkg::ST_ACC_RD:
            begin
                a_addr = AW'(corner_k);
            end
            mvna_pkg::ST_ACC_WR:
            begin
                a_addr = AW'(corner_k);
                a_we   = 1'b1;
                a_wd   = {acc_new[2], acc_new[1], acc_new[0]};
            end
            default:
            begin
            end
        endcase

        rsp_valid   = rsp_valid_reg;
        norm_x      = rx_reg;
        norm_y      = ry_reg;
        norm_z      = rz_reg;
        zero_length = rzero_reg;
    end

    // single-port memories with registered read data
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_addr] <= pos_reg;
        end
        vq_reg <= vmem[v_addr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[a_addr] <= a_wd;
        end
        aq_reg <= amem[a_addr];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvna_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mvna_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            cnt_reg <= (state_reg == mvna_pkg::ST_CROSS) ? cnt_reg + 3'd1 : 3'd0;
            if (state_reg == mvna_pkg::ST_ACC_WR)
            begin
                k_reg <= k_reg + 2'd1;
            end
            else if (state_reg == mvna_pkg::ST_NWAIT)
            begin
                k_reg <= '0;
            end
            // load wins over a take in the same cycle
            if (state_reg == mvna_pkg::ST_OUT && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == mvna_pkg::ST_IDLE && req_valid)
        begin
            func_reg <= func;
            ca_reg   <= corner_a;
            cb_reg   <= corner_b;
            cc_reg   <= corner_c;
            pos_reg  <= {pos_z, pos_y, pos_x};
        end
        if (state_reg == mvna_pkg::ST_DECODE)
        begin
            bad_reg <= !a_ok;
        end
        if (state_reg == mvna_pkg::ST_VRD1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= vq_reg[i*CW +: CW];
            end
        end
        if (state_reg == mvna_pkg::ST_VRD2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= vq_reg[i*CW +: CW];
            end
        end
        if (state_reg == mvna_pkg::ST_VRD3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(p1_reg[i]) - EW'(p0_reg[i]);
                e2_reg[i] <= EW'($signed(vq_reg[i*CW +: CW])) - EW'(p0_reg[i]);
            end
        end
        if (state_reg == mvna_pkg::ST_CROSS)
        begin
            prod_reg <= mul_a * mul_b;
            if (cnt_reg != 3'd0)
            begin
                if (!j[0])
                begin
                    nv_reg[comp] <= VW'(prod_reg);
                end
                else
                begin
                    nv_reg[comp] <= nv_reg[comp] - VW'(prod_reg);
                end
            end
        end
        if (state_reg == mvna_pkg::ST_RDDATA)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nv_reg[i] <= VW'($signed(aq_reg[i*ACC_BITS +: ACC_BITS]));
            end
        end
        if (state_reg == mvna_pkg::ST_OUT && out_free)
        begin
            rx_reg    <= bad_reg ? '0 : n_x;
            ry_reg    <= bad_reg ? '0 : n_y;
            rz_reg    <= bad_reg ? '0 : n_z;
            rzero_reg <= bad_reg ? 1'b1 : norm_st.zero;
        end
    end

endmodule

>>> rtl/mvna_checker.sv
// Port-level checks for the mesh vertex normal accumulator, bound to the top level.
// Depends on mvna_pkg.
module mvna_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_stall,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input logic signed [mvna_pkg::NORM_W-1:0]  norm_x,
    input logic signed [mvna_pkg::NORM_W-1:0]  norm_y,
    input logic signed [mvna_pkg::NORM_W-1:0]  norm_z,
    input logic                                zero_length
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(norm_x) && $stable(norm_y)
                                   && $stable(norm_z) && $stable(zero_length))
        else $error("stalled response changed");

    a_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zero_length |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
        else $error("zero-length response with nonzero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> norm_x >= -16384 && norm_x <= 16384 && norm_y >= -16384
                      && norm_y <= 16384 && norm_z >= -16384 && norm_z <= 16384)
        else $error("normal component out of Q1.14 unit range");

    // the clearing sweep holds off requests right after reset
    a_reset_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> req_stall && !rsp_valid)
        else $error("request taken during accumulator clear");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .norm_z      (norm_z),
    .zero_length (zero_length)
);
